>>> hw/rtl/cgga_pkg.sv
// Shared types and sizes for the cell gradient accumulator.
// Used by every module under hw/rtl; depends on nothing.
package cgga_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned ACC_W      = 64;
    localparam int unsigned DIV_STEPS  = ACC_W;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SAT      = 2'd1;
    localparam logic [1:0] ST_ZERO_VOL = 2'd2;

    typedef struct packed {
        logic signed [WORD_W-1:0] area_x;
        logic signed [WORD_W-1:0] area_y;
        logic signed [WORD_W-1:0] area_z;
        logic signed [WORD_W-1:0] face_value;
        logic                     negate;
        logic                     face_present;
        logic                     last_face;
        logic        [WORD_W-1:0] cell_volume;
    } t_in_word;

    typedef struct packed {
        logic signed [WORD_W-1:0] grad_x;
        logic signed [WORD_W-1:0] grad_y;
        logic signed [WORD_W-1:0] grad_z;
        logic        [1:0]        status;
    } t_out_word;

    // One closed cell on its way from the accumulators to the divider.
    typedef struct packed {
        logic signed [ACC_W-1:0]  sum_x;
        logic signed [ACC_W-1:0]  sum_y;
        logic signed [ACC_W-1:0]  sum_z;
        logic                     sum_sat;
        logic        [WORD_W-1:0] volume;
    } t_cell_sum;

endpackage

>>> hw/rtl/cgga_front.sv
// Front end: face products, saturating accumulation and cell close.
// Depends on cgga_pkg; feeds cgga_fifo.
module cgga_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  cgga_pkg::t_in_word                  i_in_word,
    input  logic [cgga_pkg::FIFO_CNT_W-1:0]     i_fifo_count,
    output logic                                o_full,
    output logic                                o_fifo_push,
    output cgga_pkg::t_cell_sum                 o_fifo_data
);

    localparam logic [cgga_pkg::FIFO_CNT_W-1:0] CNT_FULL =
        cgga_pkg::FIFO_CNT_W'(cgga_pkg::FIFO_DEPTH);
    localparam logic [cgga_pkg::FIFO_CNT_W-1:0] CNT_LAST_SLOT =
        cgga_pkg::FIFO_CNT_W'(cgga_pkg::FIFO_DEPTH - 1);

    typedef struct packed {
        logic signed [cgga_pkg::ACC_W-1:0] sum;
        logic                              ovf;
    } t_acc_res;

    logic                              r_s1_valid;
    logic                              r_s1_last;
    logic                              r_s1_present;
    logic                              r_s1_negate;
    logic signed [cgga_pkg::ACC_W-1:0] r_s1_px;
    logic signed [cgga_pkg::ACC_W-1:0] r_s1_py;
    logic signed [cgga_pkg::ACC_W-1:0] r_s1_pz;
    logic        [cgga_pkg::WORD_W-1:0] r_s1_vol;

    logic signed [cgga_pkg::ACC_W-1:0] r_sum_x;
    logic signed [cgga_pkg::ACC_W-1:0] r_sum_y;
    logic signed [cgga_pkg::ACC_W-1:0] r_sum_z;
    logic                              r_sum_sat;

    logic signed [cgga_pkg::ACC_W-1:0] n_px;
    logic signed [cgga_pkg::ACC_W-1:0] n_py;
    logic signed [cgga_pkg::ACC_W-1:0] n_pz;
    logic                              accept;
    t_acc_res                          acc_x;
    t_acc_res                          acc_y;
    t_acc_res                          acc_z;
    logic                              n_sat;

    // Add or subtract one product, clipping at the accumulator limits.
    function automatic t_acc_res sat_acc(
        input logic signed [cgga_pkg::ACC_W-1:0] s,
        input logic signed [cgga_pkg::ACC_W-1:0] p,
        input logic                              sub
    );
        t_acc_res                          res;
        logic signed [cgga_pkg::ACC_W-1:0] raw;
        logic                              same_sign;
        begin
            raw       = sub ? (s - p) : (s + p);
            same_sign = (s[cgga_pkg::ACC_W-1] == p[cgga_pkg::ACC_W-1]);
            res.ovf   = (sub ? !same_sign : same_sign)
                        && (raw[cgga_pkg::ACC_W-1] != s[cgga_pkg::ACC_W-1]);
            if (res.ovf) begin
                res.sum = s[cgga_pkg::ACC_W-1]
                          ? {1'b1, {(cgga_pkg::ACC_W-1){1'b0}}}
                          : {1'b0, {(cgga_pkg::ACC_W-1){1'b1}}};
            end else begin
                res.sum = raw;
            end
            return res;
        end
    endfunction

    // A cell close must find a queue slot in the cycle after it is accepted,
    // so a word that is still in the product stage and closes a cell holds
    // one in reserve.
    assign o_full = (i_fifo_count == CNT_FULL)
                    || (r_s1_valid && r_s1_last && (i_fifo_count == CNT_LAST_SLOT));
    assign accept = i_push && !o_full;

    assign n_px = i_in_word.area_x * i_in_word.face_value;
    assign n_py = i_in_word.area_y * i_in_word.face_value;
    assign n_pz = i_in_word.area_z * i_in_word.face_value;

    always_comb begin
        acc_x = sat_acc(r_sum_x, r_s1_present ? r_s1_px : '0, r_s1_negate);
        acc_y = sat_acc(r_sum_y, r_s1_present ? r_s1_py : '0, r_s1_negate);
        acc_z = sat_acc(r_sum_z, r_s1_present ? r_s1_pz : '0, r_s1_negate);
        n_sat = r_sum_sat || acc_x.ovf || acc_y.ovf || acc_z.ovf;
    end

    assign o_fifo_push         = r_s1_valid && r_s1_last;
    assign o_fifo_data.sum_x   = acc_x.sum;
    assign o_fifo_data.sum_y   = acc_y.sum;
    assign o_fifo_data.sum_z   = acc_z.sum;
    assign o_fifo_data.sum_sat = n_sat;
    assign o_fifo_data.volume  = r_s1_vol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_last  <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_s1_last  <= accept && i_in_word.last_face;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_present <= i_in_word.face_present;
            r_s1_negate  <= i_in_word.negate;
            r_s1_px      <= n_px;
            r_s1_py      <= n_py;
            r_s1_pz      <= n_pz;
            r_s1_vol     <= i_in_word.cell_volume;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_sum_z   <= '0;
            r_sum_sat <= 1'b0;
        end else if (r_s1_valid) begin
            if (r_s1_last) begin
                r_sum_x   <= '0;
                r_sum_y   <= '0;
                r_sum_z   <= '0;
                r_sum_sat <= 1'b0;
            end else begin
                r_sum_x   <= acc_x.sum;
                r_sum_y   <= acc_y.sum;
                r_sum_z   <= acc_z.sum;
                r_sum_sat <= n_sat;
            end
        end
    end

    a_clear_after_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_last |=> r_sum_x == '0 && r_sum_y == '0 && r_sum_z == '0
                                    && !r_sum_sat)
        else $error("accumulators not cleared after cell close");

    a_slot_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fifo_push |-> i_fifo_count != CNT_FULL)
        else $error("cell close found the queue full");

    a_close_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_word.last_face |=> r_s1_valid && r_s1_last)
        else $error("accepted cell close lost in product stage");

endmodule

>>> hw/rtl/cgga_fifo.sv
// Two-entry queue of closed cells between the front end and the divider.
// Depends on cgga_pkg.
module cgga_fifo (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  cgga_pkg::t_cell_sum                 i_data,
    input  logic                                i_pop,
    output cgga_pkg::t_cell_sum                 o_data,
    output logic                                o_empty,
    output logic [cgga_pkg::FIFO_CNT_W-1:0]     o_count
);

    localparam logic [cgga_pkg::FIFO_CNT_W-1:0] CNT_FULL =
        cgga_pkg::FIFO_CNT_W'(cgga_pkg::FIFO_DEPTH);

    cgga_pkg::t_cell_sum                 r_mem [cgga_pkg::FIFO_DEPTH];
    logic [cgga_pkg::FIFO_AW-1:0]        r_wr_ptr;
    logic [cgga_pkg::FIFO_AW-1:0]        r_rd_ptr;
    logic [cgga_pkg::FIFO_CNT_W-1:0]     r_count;

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue popped while empty");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> r_count != CNT_FULL)
        else $error("queue pushed while full");

    a_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not follow a push");

endmodule

>>> hw/rtl/cgga_divider.sv
// One gradient component: restoring divide of a signed sum by the volume,
// one quotient bit per cycle, then clip to the signed word range.
// Depends on cgga_pkg.
module cgga_divider (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [cgga_pkg::ACC_W-1:0]    i_sum,
    input  logic        [cgga_pkg::WORD_W-1:0]   i_vol,
    output logic                                 o_busy,
    output logic signed [cgga_pkg::WORD_W-1:0]   o_quot,
    output logic                                 o_clip
);

    localparam int unsigned AW = cgga_pkg::ACC_W;
    localparam int unsigned WW = cgga_pkg::WORD_W;
    localparam logic [cgga_pkg::DIV_CNT_W-1:0] LAST_STEP =
        cgga_pkg::DIV_CNT_W'(cgga_pkg::DIV_STEPS - 1);

    logic                              r_busy;
    logic [cgga_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [WW-1:0]                     r_rem;
    logic [AW-1:0]                     r_quo;
    logic [WW-1:0]                     r_vol;
    logic                              r_neg;

    logic [AW-1:0]                     mag;
    logic [WW:0]                       trial;
    logic [WW:0]                       diff;
    logic                              fits;
    logic                              clip_pos;
    logic                              clip_neg;

    assign mag   = i_sum[AW-1] ? (~i_sum + AW'(1)) : i_sum;

    // The dividend shifts out of the top of r_quo while quotient bits
    // shift in at the bottom.
    assign trial = {r_rem, r_quo[AW-1]};
    assign diff  = trial - {1'b0, r_vol};
    assign fits  = (trial >= {1'b0, r_vol});

    assign clip_pos = |r_quo[AW-1:WW-1];
    assign clip_neg = (|r_quo[AW-1:WW]) || (r_quo[WW-1] && (|r_quo[WW-2:0]));

    assign o_busy = r_busy;
    assign o_clip = r_neg ? clip_neg : clip_pos;

    always_comb begin
        if (r_neg) begin
            o_quot = clip_neg ? {1'b1, {(WW-1){1'b0}}} : (~r_quo[WW-1:0] + WW'(1));
        end else begin
            o_quot = clip_pos ? {1'b0, {(WW-1){1'b1}}} : r_quo[WW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= mag;
            r_vol <= i_vol;
            r_neg <= i_sum[AW-1];
        end else if (r_busy) begin
            r_rem <= fits ? diff[WW-1:0] : trial[WW-1:0];
            r_quo <= {r_quo[AW-2:0], fits};
        end
    end

endmodule

>>> hw/rtl/cgga_back.sv
// Back end: takes closed cells from the queue, runs three dividers in
// parallel and holds the finished gradient word in the output register.
// Depends on cgga_pkg and cgga_divider.
module cgga_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_empty,
    input  cgga_pkg::t_cell_sum    i_q_data,
    output logic                   o_q_pop,
    input  logic                   i_pop,
    output logic                   o_empty,
    output cgga_pkg::t_out_word    o_out_word
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0]              r_state;
    logic [1:0]              n_state;
    logic                    r_zero;
    logic                    r_sat;
    logic                    r_out_valid;
    cgga_pkg::t_out_word     r_out_word;
    cgga_pkg::t_out_word     n_result;

    logic                    start;
    logic                    out_free;
    logic                    load_out;
    logic                    busy_x;
    logic                    busy_y;
    logic                    busy_z;
    logic                    clip_x;
    logic                    clip_y;
    logic                    clip_z;
    logic signed [cgga_pkg::WORD_W-1:0] quot_x;
    logic signed [cgga_pkg::WORD_W-1:0] quot_y;
    logic signed [cgga_pkg::WORD_W-1:0] quot_z;

    assign out_free = !r_out_valid || i_pop;
    assign o_q_pop  = (r_state == S_IDLE) && !i_q_empty;
    assign start    = o_q_pop && (i_q_data.volume != '0);
    assign load_out = (r_state == S_HOLD) && out_free;

    cgga_divider u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sum   (i_q_data.sum_x),
        .i_vol   (i_q_data.volume),
        .o_busy  (busy_x),
        .o_quot  (quot_x),
        .o_clip  (clip_x)
    );

    cgga_divider u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sum   (i_q_data.sum_y),
        .i_vol   (i_q_data.volume),
        .o_busy  (busy_y),
        .o_quot  (quot_y),
        .o_clip  (clip_y)
    );

    cgga_divider u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sum   (i_q_data.sum_z),
        .i_vol   (i_q_data.volume),
        .o_busy  (busy_z),
        .o_quot  (quot_z),
        .o_clip  (clip_z)
    );

    always_comb begin
        if (r_zero) begin
            n_result.grad_x = '0;
            n_result.grad_y = '0;
            n_result.grad_z = '0;
            n_result.status = cgga_pkg::ST_ZERO_VOL;
        end else begin
            n_result.grad_x = quot_x;
            n_result.grad_y = quot_y;
            n_result.grad_z = quot_z;
            n_result.status = (r_sat || clip_x || clip_y || clip_z)
                              ? cgga_pkg::ST_SAT : cgga_pkg::ST_OK;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_q_pop) begin
                    n_state = start ? S_DIV : S_HOLD;
                end
            end
            S_DIV: begin
                if (!busy_x && !busy_y && !busy_z) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_zero <= (i_q_data.volume == '0);
            r_sat  <= i_q_data.sum_sat;
        end
        if (load_out) begin
            r_out_word <= n_result;
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_out_word = r_out_word;

    a_div_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy_x == busy_y && busy_y == busy_z)
        else $error("divider lanes out of step");

    a_start_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> r_state == S_DIV && busy_x)
        else $error("divider start did not enter the divide phase");

    a_held_word_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_pop |=> $stable(r_out_word))
        else $error("waiting result overwritten");

endmodule

>>> hw/rtl/cell_gauss_gradient_accumulator.sv
// Top level of the cell gradient accumulator: front end, cell queue and
// divider back end. Depends on cgga_pkg, cgga_front, cgga_fifo, cgga_back.
//
//  channel   | handshake           | word type
//  ----------+---------------------+----------------------
//  faces in  | push / full         | cgga_pkg::t_in_word
//  gradients | empty / pop         | cgga_pkg::t_out_word
//
// A face word is taken every cycle while full is low; products are
// registered, then added to the 64-bit sums in the next cycle.
// Each closed cell runs through the 64-step restoring dividers (skipped for
// a zero volume); the next cell is taken once the last result is stored.
// The queue holds two closed cells; full rises only when it cannot take
// another cell close. Reset is synchronous and clears the sums and queue.
module cell_gauss_gradient_accumulator (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  cgga_pkg::t_in_word     i_in_word,
    output logic                   empty,
    input  logic                   pop,
    output cgga_pkg::t_out_word    o_out_word
);

    logic                                q_push;
    cgga_pkg::t_cell_sum                 q_wr_data;
    logic                                q_pop;
    cgga_pkg::t_cell_sum                 q_rd_data;
    logic                                q_empty;
    logic [cgga_pkg::FIFO_CNT_W-1:0]     q_count;

    cgga_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_in_word    (i_in_word),
        .i_fifo_count (q_count),
        .o_full       (full),
        .o_fifo_push  (q_push),
        .o_fifo_data  (q_wr_data)
    );

    cgga_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .i_pop   (q_pop),
        .o_data  (q_rd_data),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    cgga_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_data   (q_rd_data),
        .o_q_pop    (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_word (o_out_word)
    );

endmodule
